@@ design/mlfq_pkg.sv @@
// Shared constants and types of the feedback queue scheduler.
package mlfq_pkg;
   localparam int NUM_LEVELS = 4;
   localparam int MAX_PROCESSES = 16;
   localparam int TIME_BITS = 48;
   localparam int SLOT_BITS = $clog2(MAX_PROCESSES + 1);
   localparam int LVL_BITS = $clog2(NUM_LEVELS);
   localparam int CNT_BITS = $clog2(MAX_PROCESSES + 1);
   localparam logic [SLOT_BITS-1:0] NIL = SLOT_BITS'(MAX_PROCESSES);

   localparam logic [1:0] CMD_ENQ = 2'd0;
   localparam logic [1:0] CMD_DEQ = 2'd1;
   localparam logic [1:0] CMD_PRE = 2'd2;
   localparam logic [1:0] CMD_CHK = 2'd3;

   localparam logic [1:0] PST_NEW = 2'd1;
   localparam logic [1:0] PST_BLOCKED = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // Datapath operations issued by the controller.
   localparam logic [3:0] OP_NONE = 4'd0;
   localparam logic [3:0] OP_LATCH = 4'd1;
   localparam logic [3:0] OP_ENQ_READY = 4'd2;
   localparam logic [3:0] OP_WALK_START = 4'd3;
   localparam logic [3:0] OP_WALK_STEP = 4'd4;
   localparam logic [3:0] OP_BLK_LINK = 4'd5;
   localparam logic [3:0] OP_DEQ = 4'd6;
   localparam logic [3:0] OP_PRE = 4'd7;
   localparam logic [3:0] OP_WAKE = 4'd8;
   localparam logic [3:0] OP_CHK_END = 4'd9;
   localparam logic [3:0] OP_FULL = 4'd10;
   localparam logic [3:0] OP_EMPTY = 4'd11;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic is_blocked;
      logic free_empty;
      logic ready_empty;
      logic walk_done;
      logic wake_due;
   } status_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] out_process_id;
      logic [1:0] out_priority;
      logic woke;
      logic [47:0] updated_time;
      logic [4:0] ready_total;
      logic [4:0] blocked_total;
      logic last;
   } result_type;
endpackage

@@ design/mlfq_scheduler_with_blocked_queue.sv @@
// Top level of the multilevel feedback queue scheduler with blocked list.
// A command is latched while idle and decided in the decide state, which
// waits while the result register holds a beat. Enqueue, dequeue and
// preempt end at the decision, with the result beat out the cycle after.
// A blocked enqueue walks the sorted list one slot a cycle, passing up to
// 15 blocked entries before it links the new process. Check blocked gives
// one beat per woken process and a final beat closing the command. The
// result register holds a beat until rsp_tready; the controller waits on it.
module mlfq_scheduler_with_blocked_queue (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // command[1:0]
   input logic [1:0] req_tuser,
   // process_id[7:0] priority_level[9:8] process_state[11:10]
   // real_time_class[12] wake_time[60:13] now_time[108:61]
   input logic [111:0] req_tdata,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // status[1:0] woke[2]
   output logic [2:0] rsp_tuser,
   // out_process_id[7:0] out_priority[9:8] updated_time[57:10]
   // ready_total[62:58] blocked_total[67:63]
   output logic [71:0] rsp_tdata,
   output logic rsp_tlast,
   input logic csr_valid,
   output logic csr_ready,
   input logic [31:0] csr_data
);
   import mlfq_pkg::*;

   logic [31:0] inc_ff;
   cmd_type cmd;
   status_type stat;
   result_type res;
   logic res_busy;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) inc_ff <= '0;
      else if (csr_valid) inc_ff <= csr_data;
   end

   mlfq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .stat(stat), .res_busy(res_busy), .cmd(cmd)
   );

   mlfq_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .in_command(req_tuser), .in_pid(req_tdata[7:0]),
      .in_level(req_tdata[9:8]), .in_pstate(req_tdata[11:10]),
      .in_rt(req_tdata[12]), .in_wake(req_tdata[60:13]),
      .in_now(req_tdata[108:61]), .wake_inc(inc_ff),
      .stat(stat), .res_busy(res_busy), .res(res),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready)
   );

   assign rsp_tuser = {res.woke, res.status};
   assign rsp_tdata = {4'b0, res.blocked_total, res.ready_total, res.updated_time,
                       res.out_priority, res.out_process_id};
   assign rsp_tlast = res.last;
endmodule

@@ design/mlfq_ctrl.sv @@
// Controller state machine of the feedback queue scheduler.
module mlfq_ctrl (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input mlfq_pkg::status_type stat,
   input logic res_busy,
   output mlfq_pkg::cmd_type cmd
);
   import mlfq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;
   localparam logic [1:0] S_WAKE = 2'd3;

   logic [1:0] state_ff, state_in;

   assign in_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.op = OP_LATCH;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!res_busy) begin
               state_in = S_IDLE;
               unique case (stat.command)
                  CMD_ENQ: begin
                     if (stat.free_empty) cmd.op = OP_FULL;
                     else if (stat.is_blocked) begin
                        cmd.op = OP_WALK_START;
                        state_in = S_WALK;
                     end else cmd.op = OP_ENQ_READY;
                  end
                  CMD_DEQ: cmd.op = stat.ready_empty ? OP_EMPTY : OP_DEQ;
                  CMD_PRE: cmd.op = stat.free_empty ? OP_FULL : OP_PRE;
                  default: state_in = S_WAKE;
               endcase
            end
         end
         S_WALK: begin
            if (stat.walk_done) begin
               if (!res_busy) begin
                  cmd.op = OP_BLK_LINK;
                  state_in = S_IDLE;
               end
            end else cmd.op = OP_WALK_STEP;
         end
         default: begin
            if (!res_busy) begin
               if (stat.wake_due) cmd.op = OP_WAKE;
               else begin
                  cmd.op = OP_CHK_END;
                  state_in = S_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

@@ design/mlfq_datapath.sv @@
// Slot stores, queue pointers and result register of the scheduler.
module mlfq_datapath (
   input logic clock,
   input logic reset,
   input mlfq_pkg::cmd_type cmd,
   input logic [1:0] in_command,
   input logic [7:0] in_pid,
   input logic [1:0] in_level,
   input logic [1:0] in_pstate,
   input logic in_rt,
   input logic [47:0] in_wake,
   input logic [47:0] in_now,
   input logic [31:0] wake_inc,
   output mlfq_pkg::status_type stat,
   output logic res_busy,
   output mlfq_pkg::result_type res,
   output logic res_valid,
   input logic res_ready
);
   import mlfq_pkg::*;

   typedef logic [SLOT_BITS-1:0] slot_type;

   logic [7:0] pid_ff [MAX_PROCESSES];
   logic [LVL_BITS-1:0] lvl_ff [MAX_PROCESSES];
   logic [TIME_BITS-1:0] wake_ff [MAX_PROCESSES];
   slot_type next_ff [MAX_PROCESSES];
   slot_type head_ff [NUM_LEVELS];
   slot_type tail_ff [NUM_LEVELS];
   slot_type bhead_ff, fhead_ff, prev_ff, cur_ff;
   logic [CNT_BITS-1:0] rcnt_ff, bcnt_ff;

   logic [1:0] c_cmd_ff;
   logic [7:0] c_pid_ff;
   logic [LVL_BITS-1:0] c_lvl_ff;
   logic c_blk_ff;
   logic [TIME_BITS-1:0] c_wake_ff, now_ff;

   result_type res_ff;
   logic res_valid_ff;
   logic res_load;

   logic [LVL_BITS-1:0] lvl_sat, lvl_enq;
   logic [LVL_BITS-1:0] top_lvl;
   logic any_ready;
   logic [TIME_BITS-1:0] now_next;
   slot_type fs, ds, bs;

   assign res = res_ff;
   assign res_valid = res_valid_ff;
   assign res_busy = res_valid_ff && !res_ready;

   assign res_load = (cmd.op == OP_ENQ_READY) || (cmd.op == OP_BLK_LINK) ||
                     (cmd.op == OP_DEQ) || (cmd.op == OP_PRE) ||
                     (cmd.op == OP_WAKE) || (cmd.op == OP_CHK_END) ||
                     (cmd.op == OP_FULL) || (cmd.op == OP_EMPTY);

   always_comb begin
      lvl_sat = (in_level > 2'(NUM_LEVELS - 1)) ? LVL_BITS'(NUM_LEVELS - 1)
                                                  : LVL_BITS'(in_level);
      lvl_enq = lvl_sat;
      if (in_command == CMD_ENQ && in_pstate != PST_BLOCKED && in_pstate != PST_NEW
          && !in_rt && lvl_sat != LVL_BITS'(NUM_LEVELS - 1))
         lvl_enq = lvl_sat + LVL_BITS'(1);
   end

   always_comb begin
      any_ready = 1'b0;
      top_lvl = '0;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (head_ff[l] != NIL) begin
            any_ready = 1'b1;
            top_lvl = LVL_BITS'(l);
         end
      end
   end

   assign fs = fhead_ff;
   assign ds = head_ff[top_lvl];
   assign bs = bhead_ff;
   assign now_next = now_ff + TIME_BITS'(wake_inc);

   always_comb begin
      stat.command = c_cmd_ff;
      stat.is_blocked = c_blk_ff;
      stat.free_empty = (fhead_ff == NIL);
      stat.ready_empty = !any_ready;
      stat.walk_done = (cur_ff == NIL) ||
                       (wake_ff[cur_ff[SLOT_BITS-2:0]] > c_wake_ff);
      stat.wake_due = (bhead_ff != NIL) &&
                      (wake_ff[bhead_ff[SLOT_BITS-2:0]] <= now_ff);
   end

   // hold a beat until taken; a new beat may load in the cycle the old one leaves
   always_ff @(posedge clock) begin
      if (reset) res_valid_ff <= 1'b0;
      else if (res_load) res_valid_ff <= 1'b1;
      else if (res_ready) res_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PROCESSES; i++) next_ff[i] <= slot_type'(i + 1);
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l] <= NIL;
            tail_ff[l] <= NIL;
         end
         bhead_ff <= NIL;
         fhead_ff <= '0;
         rcnt_ff <= '0;
         bcnt_ff <= '0;
         c_cmd_ff <= CMD_ENQ;
         c_blk_ff <= 1'b0;
         cur_ff <= NIL;
         prev_ff <= NIL;
      end else begin
         unique case (cmd.op)
            OP_LATCH: begin
               c_cmd_ff <= in_command;
               c_pid_ff <= in_pid;
               c_lvl_ff <= (in_command == CMD_ENQ) ? lvl_enq : lvl_sat;
               c_blk_ff <= (in_pstate == PST_BLOCKED);
               c_wake_ff <= in_wake;
               now_ff <= in_now;
            end
            OP_ENQ_READY: begin
               fhead_ff <= next_ff[fs[SLOT_BITS-2:0]];
               pid_ff[fs[SLOT_BITS-2:0]] <= c_pid_ff;
               lvl_ff[fs[SLOT_BITS-2:0]] <= c_lvl_ff;
               wake_ff[fs[SLOT_BITS-2:0]] <= c_wake_ff;
               next_ff[fs[SLOT_BITS-2:0]] <= NIL;
               if (head_ff[c_lvl_ff] == NIL) head_ff[c_lvl_ff] <= fs;
               else next_ff[tail_ff[c_lvl_ff][SLOT_BITS-2:0]] <= fs;
               tail_ff[c_lvl_ff] <= fs;
               rcnt_ff <= rcnt_ff + CNT_BITS'(1);
               res_ff <= '{ST_OK, c_pid_ff, 2'(c_lvl_ff), 1'b0, '0,
                           5'(rcnt_ff + CNT_BITS'(1)), 5'(bcnt_ff), 1'b1};
            end
            OP_WALK_START: begin
               prev_ff <= NIL;
               cur_ff <= bhead_ff;
            end
            OP_WALK_STEP: begin
               prev_ff <= cur_ff;
               cur_ff <= next_ff[cur_ff[SLOT_BITS-2:0]];
            end
            OP_BLK_LINK: begin
               fhead_ff <= next_ff[fs[SLOT_BITS-2:0]];
               pid_ff[fs[SLOT_BITS-2:0]] <= c_pid_ff;
               lvl_ff[fs[SLOT_BITS-2:0]] <= c_lvl_ff;
               wake_ff[fs[SLOT_BITS-2:0]] <= c_wake_ff;
               next_ff[fs[SLOT_BITS-2:0]] <= cur_ff;
               if (prev_ff != NIL) next_ff[prev_ff[SLOT_BITS-2:0]] <= fs;
               else bhead_ff <= fs;
               bcnt_ff <= bcnt_ff + CNT_BITS'(1);
               res_ff <= '{ST_OK, c_pid_ff, 2'(c_lvl_ff), 1'b0, '0,
                           5'(rcnt_ff), 5'(bcnt_ff + CNT_BITS'(1)), 1'b1};
            end
            OP_DEQ: begin
               head_ff[top_lvl] <= next_ff[ds[SLOT_BITS-2:0]];
               if (next_ff[ds[SLOT_BITS-2:0]] == NIL) tail_ff[top_lvl] <= NIL;
               next_ff[ds[SLOT_BITS-2:0]] <= fhead_ff;
               fhead_ff <= ds;
               rcnt_ff <= rcnt_ff - CNT_BITS'(1);
               res_ff <= '{ST_OK, pid_ff[ds[SLOT_BITS-2:0]],
                           2'(lvl_ff[ds[SLOT_BITS-2:0]]), 1'b0, '0,
                           5'(rcnt_ff - CNT_BITS'(1)), 5'(bcnt_ff), 1'b1};
            end
            OP_PRE: begin
               fhead_ff <= next_ff[fs[SLOT_BITS-2:0]];
               pid_ff[fs[SLOT_BITS-2:0]] <= c_pid_ff;
               lvl_ff[fs[SLOT_BITS-2:0]] <= c_lvl_ff;
               wake_ff[fs[SLOT_BITS-2:0]] <= '0;
               next_ff[fs[SLOT_BITS-2:0]] <= head_ff[c_lvl_ff];
               if (head_ff[c_lvl_ff] == NIL) tail_ff[c_lvl_ff] <= fs;
               head_ff[c_lvl_ff] <= fs;
               rcnt_ff <= rcnt_ff + CNT_BITS'(1);
               res_ff <= '{ST_OK, c_pid_ff, 2'(c_lvl_ff), 1'b0, '0,
                           5'(rcnt_ff + CNT_BITS'(1)), 5'(bcnt_ff), 1'b1};
            end
            OP_WAKE: begin
               // move blocked head to tail of its stored level
               bhead_ff <= next_ff[bs[SLOT_BITS-2:0]];
               bcnt_ff <= bcnt_ff - CNT_BITS'(1);
               next_ff[bs[SLOT_BITS-2:0]] <= NIL;
               if (head_ff[lvl_ff[bs[SLOT_BITS-2:0]]] == NIL)
                  head_ff[lvl_ff[bs[SLOT_BITS-2:0]]] <= bs;
               else
                  next_ff[tail_ff[lvl_ff[bs[SLOT_BITS-2:0]]][SLOT_BITS-2:0]] <= bs;
               tail_ff[lvl_ff[bs[SLOT_BITS-2:0]]] <= bs;
               rcnt_ff <= rcnt_ff + CNT_BITS'(1);
               now_ff <= now_next;
               res_ff <= '{ST_OK, pid_ff[bs[SLOT_BITS-2:0]],
                           2'(lvl_ff[bs[SLOT_BITS-2:0]]), 1'b1, 48'(now_next),
                           5'(rcnt_ff + CNT_BITS'(1)), 5'(bcnt_ff - CNT_BITS'(1)), 1'b0};
            end
            OP_CHK_END: begin
               res_ff <= '{ST_OK, 8'd0, 2'd0, 1'b0, 48'(now_ff),
                           5'(rcnt_ff), 5'(bcnt_ff), 1'b1};
            end
            OP_FULL: begin
               res_ff <= '{ST_FULL, c_pid_ff, 2'(c_lvl_ff), 1'b0, '0,
                           5'(rcnt_ff), 5'(bcnt_ff), 1'b1};
            end
            OP_EMPTY: begin
               res_ff <= '{ST_EMPTY, 8'd0, 2'd0, 1'b0, '0,
                           5'(rcnt_ff), 5'(bcnt_ff), 1'b1};
            end
            default: ;
         endcase
      end
   end
endmodule
